### rtl/core/tbcs_pkg.sv
// shared types, register indexes and brightness mapping for the click/hold selector
// no dependencies
`default_nettype none

package tbcs_pkg;

    localparam int unsigned HoldW   = 16;
    localparam int unsigned CountW  = 8;
    localparam int unsigned FloorW  = 7;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 16;

    localparam logic [HoldW-1:0]  HoldMax = '1;

    localparam logic [CfgIdxW-1:0] CFG_CLICK_MIN  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOLD_MIN   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_OFF_HOLD   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_BRT_FLOOR  = 2'd3;

    localparam logic [HoldW-1:0]  CLICK_MIN_RST  = 16'd2;
    localparam logic [HoldW-1:0]  HOLD_MIN_RST   = 16'd20;
    localparam logic [HoldW-1:0]  OFF_HOLD_RST   = 16'd160;
    localparam logic [FloorW-1:0] BRT_FLOOR_RST  = 7'd10;
    localparam logic [CountW-1:0] BRT_COUNT_RST  = 8'd8;

    localparam logic [3:0]  BRT_WRAP_STEPS = 4'd13;
    localparam logic [3:0]  BRT_STEP       = 4'd10;
    localparam logic [6:0]  RECIP_13       = 7'd79;
    localparam logic [8:0]  BRT_MAX        = 9'd255;

    typedef struct packed {
        logic effect_step;
        logic click_step;
        logic shutdown;
        logic off_hit;
    } tbcs_event_t;

    typedef struct packed {
        logic [HoldW-1:0] click_min;
        logic [HoldW-1:0] hold_min;
        logic [HoldW-1:0] off_hold;
    } tbcs_thresh_t;

    // ((count*10) mod 130) + floor, saturated; mod 13 via reciprocal multiply
    function automatic logic [CountW-1:0] brightness_map(
        input logic [CountW-1:0] count,
        input logic [FloorW-1:0] floor_val
    );
        logic [14:0] prod;
        logic [4:0]  quo;
        logic [7:0]  rem;
        logic [8:0]  lvl;
        prod = {7'd0, count} * {8'd0, RECIP_13};
        quo  = prod[14:10];
        rem  = count - 8'({3'd0, quo} * {4'd0, BRT_WRAP_STEPS});
        lvl  = 9'({5'd0, rem[3:0]} * {5'd0, BRT_STEP}) + {2'd0, floor_val};
        if (lvl > BRT_MAX)
        begin
            lvl = BRT_MAX;
        end
        return lvl[CountW-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/tbcs_button.sv
// per-button level tracking and hold counter, classifies release, press and held events
// depends on tbcs_pkg
`default_nettype none

module tbcs_button
    import tbcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic         level,
    input  wire tbcs_thresh_t thresh,
    output tbcs_event_t       ev
);

    logic             last_reg;
    logic             last_next;
    logic [HoldW-1:0] hold_reg;
    logic [HoldW-1:0] hold_next;

    logic released;
    logic pressed;
    logic held;
    logic at_off;
    logic in_hold;
    logic in_click;

    always_comb
    begin
        released = level & ~last_reg;
        pressed  = ~level & last_reg;
        held     = ~level & ~last_reg;
        at_off   = hold_reg >= thresh.off_hold;
        in_hold  = !at_off && (hold_reg >= thresh.hold_min);
        in_click = (hold_reg < thresh.hold_min) && (hold_reg >= thresh.click_min);

        ev.effect_step = released & in_hold;
        ev.click_step  = released & ~in_hold & in_click;
        ev.shutdown    = pressed & at_off;
        ev.off_hit     = held & at_off;

        last_next = level;
        hold_next = hold_reg;
        if (pressed)
        begin
            hold_next = '0;
        end
        else if (held && (hold_reg != HoldMax))
        begin
            hold_next = hold_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
            hold_reg <= '0;
        end
        else if (advance)
        begin
            last_reg <= last_next;
            hold_reg <= hold_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_clears_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pressed |=> hold_reg == '0)
        else $error("hold count not cleared on press");
    a_hold_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && held && hold_reg == HoldMax |=> hold_reg == HoldMax)
        else $error("hold count wrapped");
    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ev.effect_step, ev.click_step, ev.shutdown, ev.off_hit}))
        else $error("button raised more than one event");
`endif

endmodule

`default_nettype wire

### rtl/core/two_button_click_hold_selector.sv
// top level of the two-button click/hold selector: config registers, counters, result register
// depends on tbcs_pkg and tbcs_button
//
// usage:
//   input channel carries one tick of two active-low button levels (left_level,
//   right_level); a transaction completes when in_valid is high and in_stall low
//   output channel carries one result per input transaction: changed, lights_off,
//   shutdown_request, effect_select, palette_number and brightness_level
//   the result appears on the output register in the cycle after the input transaction
//   throughput is one tick per cycle while in_stall is low; the whole update is one
//   pass of compare and increment logic in front of the result register
//   in_stall rises only while the result register holds an untaken result and
//   out_stall is high; a result taken in the same cycle frees the slot
//   configuration: cfg_write with cfg_index 0 click_min_ticks, 1 hold_min_ticks,
//   2 off_hold_ticks, 3 brightness_floor (low 7 bits of cfg_data)
//   reset: both buttons read as pressed with zero hold count, counters zero
//   except brightness at eight, turn-off flag clear, thresholds at defaults,
//   no result pending
`default_nettype none

module two_button_click_hold_selector
    import tbcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               left_level,
    input  wire logic               right_level,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    changed,
    output logic                    lights_off,
    output logic                    shutdown_request,
    output logic                    effect_select,
    output logic [CountW-1:0]       palette_number,
    output logic [CountW-1:0]       brightness_level,
    input  wire logic               cfg_write,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [CfgW-1:0]    cfg_data
);

    tbcs_thresh_t      thresh_reg;
    logic [FloorW-1:0] floor_reg;

    logic [CountW-1:0] effect_reg;
    logic [CountW-1:0] effect_next;
    logic [CountW-1:0] palette_reg;
    logic [CountW-1:0] palette_next;
    logic [CountW-1:0] bright_reg;
    logic [CountW-1:0] bright_next;
    logic              off_reg;
    logic              off_next;

    logic              out_valid_reg;
    logic              changed_reg;
    logic              changed_next;
    logic              shutdown_reg;
    logic              shutdown_next;
    logic [CountW-1:0] level_reg;

    logic              accept;
    tbcs_event_t       ev_l;
    tbcs_event_t       ev_r;
    logic [CountW-1:0] effect_mid;
    logic [CountW-1:0] palette_mid;
    logic [CountW-1:0] bright_mid;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    tbcs_button u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .level   (left_level),
        .thresh  (thresh_reg),
        .ev      (ev_l)
    );

    tbcs_button u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .level   (right_level),
        .thresh  (thresh_reg),
        .ev      (ev_r)
    );

    // left steps up first, right steps down using the updated mode
    always_comb
    begin
        effect_mid  = effect_reg + {7'd0, ev_l.effect_step};
        palette_mid = palette_reg;
        bright_mid  = bright_reg;
        if (ev_l.click_step)
        begin
            if (effect_reg[0])
            begin
                bright_mid = bright_reg + 1'b1;
            end
            else
            begin
                palette_mid = palette_reg + 1'b1;
            end
        end

        effect_next  = effect_mid - {7'd0, ev_r.effect_step};
        palette_next = palette_mid;
        bright_next  = bright_mid;
        if (ev_r.click_step)
        begin
            if (effect_mid[0])
            begin
                bright_next = bright_mid - 1'b1;
            end
            else
            begin
                palette_next = palette_mid - 1'b1;
            end
        end

        off_next      = off_reg | ev_l.off_hit | ev_r.off_hit;
        shutdown_next = ev_l.shutdown | ev_r.shutdown;
        changed_next  = ev_l.effect_step | ev_l.click_step | ev_l.off_hit
                      | ev_r.effect_step | ev_r.click_step | ev_r.off_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.click_min <= CLICK_MIN_RST;
            thresh_reg.hold_min  <= HOLD_MIN_RST;
            thresh_reg.off_hold  <= OFF_HOLD_RST;
            floor_reg            <= BRT_FLOOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CLICK_MIN: thresh_reg.click_min <= cfg_data;
                CFG_HOLD_MIN:  thresh_reg.hold_min  <= cfg_data;
                CFG_OFF_HOLD:  thresh_reg.off_hold  <= cfg_data;
                CFG_BRT_FLOOR: floor_reg            <= cfg_data[FloorW-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_reg    <= '0;
            palette_reg   <= '0;
            bright_reg    <= BRT_COUNT_RST;
            off_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                effect_reg  <= effect_next;
                palette_reg <= palette_next;
                bright_reg  <= bright_next;
                off_reg     <= off_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            changed_reg  <= changed_next;
            shutdown_reg <= shutdown_next;
            level_reg    <= brightness_map(bright_next, floor_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign changed          = changed_reg;
    assign lights_off       = off_reg;
    assign shutdown_request = shutdown_reg;
    assign effect_select    = effect_reg[0];
    assign palette_number   = palette_reg;
    assign brightness_level = level_reg;

`ifndef NO_ASSERTIONS
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");
    a_off_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg |=> off_reg)
        else $error("turn-off flag cleared");
    a_off_sets_changed: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (ev_l.off_hit || ev_r.off_hit) |=> changed_reg && off_reg)
        else $error("turn-off hold not flagged as change");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> level_reg <= 8'd247)
        else $error("brightness level out of range");
`endif

endmodule

`default_nettype wire
